// ===== rtl/dps_pkg.sv =====
// Shared types and constants for the display power sequencer.
// Holds the word structs, configuration struct, phase encoding and reset values.
// No dependencies.
package dps_pkg;

	localparam int unsigned PADDR_W = 4;
	localparam int unsigned PDATA_W = 32;

	// Input mode codes
	localparam logic [1:0] MODE_TICK      = 2'd0;
	localparam logic [1:0] MODE_HEARTBEAT = 2'd1;
	localparam logic [1:0] MODE_POWER     = 2'd2;

	// Register indexes
	localparam logic [1:0] REG_PULSE     = 2'd0;
	localparam logic [1:0] REG_ON_WAIT   = 2'd1;
	localparam logic [1:0] REG_OFF_WAIT  = 2'd2;
	localparam logic [1:0] REG_HEARTBEAT = 2'd3;

	// Register reset values
	localparam logic [15:0] PULSE_MS_RST     = 16'd100;
	localparam logic [16:0] ON_WAIT_MS_RST   = 17'd90000;
	localparam logic [16:0] OFF_WAIT_MS_RST  = 17'd30000;
	localparam logic [15:0] HEARTBEAT_MS_RST = 16'd10000;

	typedef enum logic [3:0] {
		PH_IDLE     = 4'b0001,
		PH_PULSE    = 4'b0010,
		PH_ON_WAIT  = 4'b0100,
		PH_OFF_WAIT = 4'b1000
	} phase_t;

	typedef struct packed {
		logic [1:0] mode;
		logic       mirror_bit;
		logic       power_on;
	} in_t;

	typedef struct packed {
		logic pin_level;
		logic started_flag;
		logic mirroring;
		logic busy_res;
	} out_t;

	typedef struct packed {
		logic [15:0] pulse_ms;
		logic [16:0] on_wait_ms;
		logic [16:0] off_wait_ms;
		logic [15:0] heartbeat_ms;
	} cfg_t;

	typedef struct packed {
		phase_t      phase;
		logic [16:0] phase_timer;
		logic [15:0] silence;
		logic        started;
		logic        mirror;
		logic        req_power;
		logic        pending;
		logic        pin;
	} state_t;

endpackage

// ===== rtl/display_power_sequencer.sv =====
// Top level of the display power sequencer: input word register, result register.
// Depends on dps_pkg, dps_apb_regs and dps_core.
//
// Each input word (tick, heartbeat or power request) is registered, applied to the
// sequencer state, and its result word is registered on the output. One
// word is accepted per cycle when the output is taken; the result is valid once the word
// advances from in_s1 into res_s2. dps_core updates its state when the word advances.
// Timing registers are in ticks; configure them only while no word is in flight.
module display_power_sequencer (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  dps_pkg::in_t                in_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output dps_pkg::out_t               out_data,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [dps_pkg::PADDR_W-1:0] paddr,
	input  logic [dps_pkg::PDATA_W-1:0] pwdata,
	output logic [dps_pkg::PDATA_W-1:0] prdata,
	output logic                        pready
);

	dps_pkg::cfg_t cfg;
	dps_pkg::in_t  in_s1;
	dps_pkg::out_t res;
	dps_pkg::out_t res_s2;
	logic          v_s1;
	logic          v_s2;
	logic          adv;

	assign adv      = v_s1 && (!v_s2 || out_ready);
	assign in_ready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (in_ready)
				v_s1 <= in_valid;
			if (adv)
				v_s2 <= 1'b1;
			else if (out_ready)
				v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			in_s1 <= in_data;
		if (adv)
			res_s2 <= res;
	end

	dps_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	dps_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv),
		.item   (in_s1),
		.cfg    (cfg),
		.res    (res)
	);

	assign out_valid = v_s2;
	assign out_data  = res_s2;

endmodule

// ===== rtl/dps_apb_regs.sv =====
// APB configuration registers of the display power sequencer.
// Depends on dps_pkg for the configuration struct, register indexes and reset values.
module dps_apb_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [dps_pkg::PADDR_W-1:0] paddr,
	input  logic [dps_pkg::PDATA_W-1:0] pwdata,
	output logic [dps_pkg::PDATA_W-1:0] prdata,
	output logic                        pready,
	output dps_pkg::cfg_t               cfg
);

	dps_pkg::cfg_t cfg_q;
	logic [1:0]    idx;
	logic          wr_en;

	assign idx    = paddr[3:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pulse_ms     <= dps_pkg::PULSE_MS_RST;
			cfg_q.on_wait_ms   <= dps_pkg::ON_WAIT_MS_RST;
			cfg_q.off_wait_ms  <= dps_pkg::OFF_WAIT_MS_RST;
			cfg_q.heartbeat_ms <= dps_pkg::HEARTBEAT_MS_RST;
		end else if (wr_en) begin
			case (idx)
				dps_pkg::REG_PULSE:     cfg_q.pulse_ms     <= pwdata[15:0];
				dps_pkg::REG_ON_WAIT:   cfg_q.on_wait_ms   <= pwdata[16:0];
				dps_pkg::REG_OFF_WAIT:  cfg_q.off_wait_ms  <= pwdata[16:0];
				dps_pkg::REG_HEARTBEAT: cfg_q.heartbeat_ms <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			dps_pkg::REG_PULSE:     prdata = {16'd0, cfg_q.pulse_ms};
			dps_pkg::REG_ON_WAIT:   prdata = {15'd0, cfg_q.on_wait_ms};
			dps_pkg::REG_OFF_WAIT:  prdata = {15'd0, cfg_q.off_wait_ms};
			dps_pkg::REG_HEARTBEAT: prdata = {16'd0, cfg_q.heartbeat_ms};
			default:                prdata = '0;
		endcase
	end

endmodule

// ===== rtl/dps_core.sv =====
// Sequencer state and single-pass next-state logic for the display power sequencer.
// Depends on dps_pkg for word, configuration and state types.
module dps_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  dps_pkg::in_t  item,
	input  dps_pkg::cfg_t cfg,
	output dps_pkg::out_t res
);

	dps_pkg::state_t cur_q;
	dps_pkg::state_t nx;

	function automatic dps_pkg::state_t begin_seq(input dps_pkg::state_t si);
		dps_pkg::state_t s;
		s = si;
		s.phase_timer = '0;
		if (s.req_power) begin
			if (!s.started) begin
				s.pin   = 1'b1;
				s.phase = dps_pkg::PH_PULSE;
			end else begin
				s.phase = dps_pkg::PH_IDLE;
			end
		end else begin
			s.phase = s.started ? dps_pkg::PH_OFF_WAIT : dps_pkg::PH_IDLE;
		end
		return s;
	endfunction

	function automatic dps_pkg::state_t end_seq(input dps_pkg::state_t si);
		dps_pkg::state_t s;
		s = si;
		s.phase       = dps_pkg::PH_IDLE;
		s.phase_timer = '0;
		if (s.pending) begin
			s.pending = 1'b0;
			s = begin_seq(s);
		end
		return s;
	endfunction

	function automatic dps_pkg::state_t tick(input dps_pkg::state_t si,
			input dps_pkg::cfg_t c);
		dps_pkg::state_t s;
		logic [16:0]     t;
		s = si;
		t = s.phase_timer + 17'd1;
		if (s.silence >= c.heartbeat_ms)
			s.started = 1'b0;
		else
			s.silence = s.silence + 16'd1;
		case (s.phase)
			dps_pkg::PH_PULSE: begin
				s.phase_timer = t;
				if (t >= {1'b0, c.pulse_ms}) begin
					s.pin         = 1'b0;
					s.phase_timer = '0;
					if (s.started)
						s = end_seq(s);
					else
						s.phase = dps_pkg::PH_ON_WAIT;
				end
			end
			dps_pkg::PH_ON_WAIT: begin
				if (s.started) begin
					s = end_seq(s);
				end else begin
					s.phase_timer = t;
					if (t >= c.on_wait_ms) begin
						s.pin         = 1'b1;
						s.phase_timer = '0;
						s.phase       = dps_pkg::PH_PULSE;
					end
				end
			end
			dps_pkg::PH_OFF_WAIT: begin
				if (!s.started) begin
					s.pin = 1'b1;
					s = end_seq(s);
				end else begin
					s.phase_timer = t;
					if (t >= c.off_wait_ms) begin
						s.pin         = 1'b1;
						s.phase_timer = '0;
					end
				end
			end
			default: ;
		endcase
		return s;
	endfunction

	always_comb begin
		nx = cur_q;
		case (item.mode)
			dps_pkg::MODE_TICK: nx = tick(cur_q, cfg);
			dps_pkg::MODE_HEARTBEAT: begin
				nx.mirror  = item.mirror_bit;
				nx.started = 1'b1;
				nx.silence = '0;
				if (cur_q.phase == dps_pkg::PH_ON_WAIT)
					nx = end_seq(nx);
			end
			dps_pkg::MODE_POWER: begin
				nx.req_power = item.power_on;
				if (cur_q.phase == dps_pkg::PH_IDLE)
					nx = begin_seq(nx);
				else
					nx.pending = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q.phase       <= dps_pkg::PH_IDLE;
			cur_q.phase_timer <= '0;
			cur_q.silence     <= '0;
			cur_q.started     <= 1'b0;
			cur_q.mirror      <= 1'b0;
			cur_q.req_power   <= 1'b0;
			cur_q.pending     <= 1'b0;
			cur_q.pin         <= 1'b0;
		end else if (step) begin
			cur_q <= nx;
		end
	end

	assign res.pin_level    = nx.pin;
	assign res.started_flag = nx.started;
	assign res.mirroring    = nx.mirror;
	assign res.busy_res     = (nx.phase != dps_pkg::PH_IDLE);

endmodule
